// ===== rtl/pa_pkg.sv =====
// Shared types and constants of the primitive assembly block.
`timescale 1ns / 1ps
`default_nettype none

package pa_pkg;

   typedef enum logic [1:0] {
      REQ_BEGIN  = 2'd0,
      REQ_VERTEX = 2'd1,
      REQ_END    = 2'd2,
      REQ_COLOR  = 2'd3
   } req_kind_type;

   localparam logic [3:0] MODE_LINES = 4'd1;
   localparam logic [3:0] MODE_LOOP  = 4'd2;
   localparam logic [3:0] MODE_STRIP = 4'd3;
   localparam logic [3:0] MODE_TRIS  = 4'd4;
   localparam logic [3:0] MODE_QUADS = 4'd7;
   localparam logic [3:0] MODE_LAST  = 4'd9;

   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_TRI  = 2'd1;
   localparam logic [1:0] KIND_QUAD = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_OP    = 2'd1;
   localparam logic [1:0] ST_BAD_VALUE = 2'd2;

   localparam logic [31:0] COLOR_ONE = 32'h3F80_0000;
   localparam int          COLOR_W   = 128;

   // Work orders passed from the front to the back.
   typedef enum logic [2:0] {
      OP_ERROR = 3'd0,
      OP_STORE = 3'd1,
      OP_LINE  = 3'd2,
      OP_CLOSE = 3'd3,
      OP_POLY  = 3'd4
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] status;
      logic [1:0] kind;
      logic [1:0] slot;
      logic       first;
   } cmd_ctl_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] corner;
      logic [1:0] status;
      logic       last;
   } rsp_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/pa_queue.sv =====
// Small register FIFO that decouples the front and back of primitive assembly.
`timescale 1ns / 1ps
`default_nettype none

module pa_queue #(
   parameter int DATA_W = 300,
   parameter int DEPTH  = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   not_empty
);

   // DEPTH must be a power of two so that the pointers wrap by themselves.
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pa_front.sv =====
// Front of primitive assembly: accepts requests, tracks begin/end state and issues work orders.
`timescale 1ns / 1ps
`default_nettype none

module pa_front #(
   parameter int POS_W = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_type,
   input  wire logic [3:0]                   prim_mode,
   input  wire logic [4*POS_W-1:0]           pos,
   input  wire logic [pa_pkg::COLOR_W-1:0]   color_req,
   input  wire logic                         q_full,
   output logic                              push,
   output pa_pkg::cmd_ctl_type               cmd_ctl,
   output logic [pa_pkg::COLOR_W+4*POS_W-1:0] cmd_vtx
);

   logic                       inside_ff, inside_in;
   logic [3:0]                 mode_ff, mode_in;
   logic                       pair_odd_ff, pair_odd_in;
   logic                       strip_first_ff, strip_first_in;
   logic [1:0]                 loop_count_ff, loop_count_in;
   logic [1:0]                 corner_count_ff, corner_count_in;
   logic [pa_pkg::COLOR_W-1:0] color_ff, color_in;
   logic                       accept;
   logic [1:0]                 last_corner;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;
   // Each vertex takes the colour current at the time it arrives.
   assign cmd_vtx   = {color_ff, pos};

   always_comb begin
      inside_in       = inside_ff;
      mode_in         = mode_ff;
      pair_odd_in     = pair_odd_ff;
      strip_first_in  = strip_first_ff;
      loop_count_in   = loop_count_ff;
      corner_count_in = corner_count_ff;
      color_in        = color_ff;
      push            = 1'b0;
      cmd_ctl         = '{op: pa_pkg::OP_ERROR, status: pa_pkg::ST_OK,
                          kind: pa_pkg::KIND_LINE, slot: 2'd0, first: 1'b0};
      last_corner     = (mode_ff == pa_pkg::MODE_TRIS) ? 2'd2 : 2'd3;

      if (accept) begin
         unique case (pa_pkg::req_kind_type'(req_type))
            pa_pkg::REQ_COLOR: begin
               color_in = color_req;
            end
            pa_pkg::REQ_BEGIN: begin
               if (inside_ff) begin
                  push           = 1'b1;
                  cmd_ctl.status = pa_pkg::ST_BAD_OP;
               end else if (prim_mode > pa_pkg::MODE_LAST) begin
                  push           = 1'b1;
                  cmd_ctl.status = pa_pkg::ST_BAD_VALUE;
               end else begin
                  inside_in = 1'b1;
                  mode_in   = prim_mode;
                  unique case (prim_mode)
                     pa_pkg::MODE_LINES: pair_odd_in = 1'b1;
                     pa_pkg::MODE_LOOP:  loop_count_in = 2'd0;
                     pa_pkg::MODE_STRIP: strip_first_in = 1'b1;
                     pa_pkg::MODE_TRIS,
                     pa_pkg::MODE_QUADS: corner_count_in = 2'd0;
                     default: ;
                  endcase
               end
            end
            pa_pkg::REQ_END: begin
               if (!inside_ff) begin
                  push           = 1'b1;
                  cmd_ctl.status = pa_pkg::ST_BAD_OP;
               end else begin
                  inside_in = 1'b0;
                  // A loop is closed only once it has at least three vertices.
                  if (mode_ff == pa_pkg::MODE_LOOP && loop_count_ff == 2'd3) begin
                     push       = 1'b1;
                     cmd_ctl.op = pa_pkg::OP_CLOSE;
                  end
               end
            end
            pa_pkg::REQ_VERTEX: begin
               if (!inside_ff) begin
                  push           = 1'b1;
                  cmd_ctl.status = pa_pkg::ST_BAD_OP;
               end else begin
                  unique case (mode_ff)
                     pa_pkg::MODE_LINES: begin
                        pair_odd_in = !pair_odd_ff;
                        push        = 1'b1;
                        cmd_ctl.op  = pair_odd_ff ? pa_pkg::OP_STORE : pa_pkg::OP_LINE;
                     end
                     pa_pkg::MODE_LOOP: begin
                        push = 1'b1;
                        if (loop_count_ff == 2'd0) begin
                           loop_count_in = 2'd1;
                           cmd_ctl.op    = pa_pkg::OP_STORE;
                           cmd_ctl.first = 1'b1;
                        end else begin
                           if (loop_count_ff != 2'd3) begin
                              loop_count_in = loop_count_ff + 2'd1;
                           end
                           cmd_ctl.op = pa_pkg::OP_LINE;
                        end
                     end
                     pa_pkg::MODE_STRIP: begin
                        push           = 1'b1;
                        strip_first_in = 1'b0;
                        cmd_ctl.op     = strip_first_ff ? pa_pkg::OP_STORE : pa_pkg::OP_LINE;
                     end
                     pa_pkg::MODE_TRIS,
                     pa_pkg::MODE_QUADS: begin
                        push         = 1'b1;
                        cmd_ctl.kind = (mode_ff == pa_pkg::MODE_TRIS) ?
                                       pa_pkg::KIND_TRI : pa_pkg::KIND_QUAD;
                        if (corner_count_ff == last_corner) begin
                           corner_count_in = 2'd0;
                           cmd_ctl.op      = pa_pkg::OP_POLY;
                        end else begin
                           corner_count_in = corner_count_ff + 2'd1;
                           cmd_ctl.op      = pa_pkg::OP_STORE;
                           cmd_ctl.slot    = corner_count_ff;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff       <= 1'b0;
         mode_ff         <= 4'd0;
         pair_odd_ff     <= 1'b0;
         strip_first_ff  <= 1'b0;
         loop_count_ff   <= 2'd0;
         corner_count_ff <= 2'd0;
         color_ff        <= {4{pa_pkg::COLOR_ONE}};
      end else begin
         inside_ff       <= inside_in;
         mode_ff         <= mode_in;
         pair_odd_ff     <= pair_odd_in;
         strip_first_ff  <= strip_first_in;
         loop_count_ff   <= loop_count_in;
         corner_count_ff <= corner_count_in;
         color_ff        <= color_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pa_back.sv =====
// Back of primitive assembly: holds vertices, plays out one beat per cycle while not stalled.
`timescale 1ns / 1ps
`default_nettype none

module pa_back #(
   parameter int POS_W = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                q_valid,
   input  wire pa_pkg::cmd_ctl_type                 q_ctl,
   input  wire logic [pa_pkg::COLOR_W+4*POS_W-1:0]  q_vtx,
   output logic                                     q_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output pa_pkg::rsp_ctl_type                      rsp_ctl,
   output logic [pa_pkg::COLOR_W+4*POS_W-1:0]       rsp_vtx
);

   localparam int VTX_W = pa_pkg::COLOR_W + 4 * POS_W;

   logic [VTX_W-1:0]    held_ff [3];
   logic [VTX_W-1:0]    first_ff;
   logic [1:0]          beat_ff, beat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pa_pkg::rsp_ctl_type rsp_ctl_ff, rsp_ctl_in;
   logic [VTX_W-1:0]    rsp_vtx_ff, rsp_vtx_in;
   logic [1:0]          last_idx;
   logic                last_beat;
   logic                out_free;
   logic                step;
   logic                emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ctl   = rsp_ctl_ff;
   assign rsp_vtx   = rsp_vtx_ff;

   always_comb begin
      unique case (q_ctl.op)
         pa_pkg::OP_LINE,
         pa_pkg::OP_CLOSE: last_idx = 2'd1;
         pa_pkg::OP_POLY:  last_idx = (q_ctl.kind == pa_pkg::KIND_QUAD) ? 2'd3 : 2'd2;
         default:          last_idx = 2'd0;
      endcase

      out_free  = !rsp_valid_ff || rsp_ready;
      // A store produces no beat, so it does not wait for the output register.
      step      = q_valid && (q_ctl.op == pa_pkg::OP_STORE || out_free);
      emit      = step && q_ctl.op != pa_pkg::OP_STORE;
      last_beat = (beat_ff == last_idx);
      q_pop     = step && last_beat;
      beat_in   = step ? (last_beat ? 2'd0 : beat_ff + 2'd1) : beat_ff;

      rsp_valid_in = out_free ? emit : rsp_valid_ff;

      rsp_ctl_in.kind   = (q_ctl.op == pa_pkg::OP_POLY) ? q_ctl.kind : pa_pkg::KIND_LINE;
      rsp_ctl_in.corner = beat_ff;
      rsp_ctl_in.status = (q_ctl.op == pa_pkg::OP_ERROR) ? q_ctl.status : pa_pkg::ST_OK;
      rsp_ctl_in.last   = last_beat;

      unique case (q_ctl.op)
         pa_pkg::OP_LINE:  rsp_vtx_in = (beat_ff == 2'd0) ? held_ff[0] : q_vtx;
         pa_pkg::OP_CLOSE: rsp_vtx_in = (beat_ff == 2'd0) ? held_ff[0] : first_ff;
         pa_pkg::OP_POLY: begin
            if (last_beat) begin
               rsp_vtx_in = q_vtx;
            end else begin
               unique case (beat_ff)
                  2'd0:    rsp_vtx_in = held_ff[0];
                  2'd1:    rsp_vtx_in = held_ff[1];
                  default: rsp_vtx_in = held_ff[2];
               endcase
            end
         end
         default: rsp_vtx_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && emit) begin
         rsp_ctl_ff <= rsp_ctl_in;
         rsp_vtx_ff <= rsp_vtx_in;
      end
      if (step && q_ctl.op == pa_pkg::OP_STORE) begin
         held_ff[q_ctl.slot] <= q_vtx;
         if (q_ctl.first) begin
            first_ff <= q_vtx;
         end
      end
      // Strips and loops carry the newest vertex forward once the line has gone out.
      if (q_pop && q_ctl.op == pa_pkg::OP_LINE) begin
         held_ff[0] <= q_vtx;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/primitive_assembly.sv =====
// Top level of the primitive assembly block: request front, work queue and vertex back.
`timescale 1ns / 1ps
`default_nettype none

// Groups begin, vertex, end and colour requests into lines, triangles and quads, and sends
// each finished primitive out as a run of vertex beats with tlast on its final vertex; misuse
// gives a single error beat. The front takes one request per cycle whenever the two-entry
// work queue has room. The back sends one result beat per cycle from its output register
// while rsp_tready allows: a line goes out as two beats, a triangle as three and a quad as
// four, so a line strip or loop sends two beats per vertex. A result passes through the work
// queue and then the output register. Positions keep their low COORD_BITS bits (at most 32);
// the rest read as zero.
module primitive_assembly #(
   parameter int COORD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // prim_mode, pos_x, pos_y, pos_z, pos_w, red_in, green_in, blue_in, alpha_in, zero pad
   input  wire logic [263:0] req_tdata,
   // req_type
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // corner, out_x, out_y, out_z, out_w, out_red, out_green, out_blue, out_alpha, zero pad
   output logic [263:0]      rsp_tdata,
   // prim_kind, status
   output logic [3:0]        rsp_tuser,
   // last_of_run
   output logic              rsp_tlast
);

   localparam int POS_W  = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int VTX_W  = pa_pkg::COLOR_W + 4 * POS_W;
   localparam int CTL_W  = $bits(pa_pkg::cmd_ctl_type);
   localparam int Q_W    = CTL_W + VTX_W;

   logic [4*POS_W-1:0]         pos;
   logic [pa_pkg::COLOR_W-1:0] color_in;
   logic                       push;
   pa_pkg::cmd_ctl_type        cmd_ctl;
   logic [VTX_W-1:0]           cmd_vtx;
   logic                       q_full;
   logic                       q_pop;
   logic                       q_valid;
   logic [Q_W-1:0]             q_data;
   pa_pkg::rsp_ctl_type        rsp_ctl;
   logic [VTX_W-1:0]           rsp_vtx;

   assign pos = {req_tdata[100 +: POS_W], req_tdata[68 +: POS_W],
                 req_tdata[36 +: POS_W], req_tdata[4 +: POS_W]};
   assign color_in = req_tdata[259:132];

   pa_front #(
      .POS_W (POS_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_type  (req_tuser),
      .prim_mode (req_tdata[3:0]),
      .pos       (pos),
      .color_req (color_in),
      .q_full    (q_full),
      .push      (push),
      .cmd_ctl   (cmd_ctl),
      .cmd_vtx   (cmd_vtx)
   );

   pa_queue #(
      .DATA_W (Q_W),
      .DEPTH  (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({cmd_ctl, cmd_vtx}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_valid)
   );

   pa_back #(
      .POS_W (POS_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ctl     (pa_pkg::cmd_ctl_type'(q_data[Q_W-1:VTX_W])),
      .q_vtx     (q_data[VTX_W-1:0]),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_ctl   (rsp_ctl),
      .rsp_vtx   (rsp_vtx)
   );

   assign rsp_tdata = {6'd0,
                       rsp_vtx[VTX_W-1:4*POS_W],
                       32'(rsp_vtx[3*POS_W +: POS_W]),
                       32'(rsp_vtx[2*POS_W +: POS_W]),
                       32'(rsp_vtx[POS_W +: POS_W]),
                       32'(rsp_vtx[0 +: POS_W]),
                       rsp_ctl.corner};
   assign rsp_tuser = {rsp_ctl.status, rsp_ctl.kind};
   assign rsp_tlast = rsp_ctl.last;

endmodule

`default_nettype wire
